[hdl/quaternion_vector_rotate_defines.svh]
// Assertion macros used by the quaternion rotate top level.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH

// same-cycle implication
`define QVR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qvr same-cycle check failed");

// next-cycle implication
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qvr next-cycle check failed");

`endif

[hdl/qvr_pkg.sv]
// Shared constants and types for the quaternion vector rotate block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

   localparam int NUM_AXES    = 3;
   localparam int STATUS_BITS = 2;

   typedef logic [STATUS_BITS-1:0] status_type;

   localparam status_type STATUS_OK   = 2'd0;
   localparam status_type STATUS_ZERO = 2'd1;
   localparam status_type STATUS_SAT  = 2'd2;

   // product terms per output axis: s*v, d*u, cross*w
   localparam int NUM_TERMS = 3;
   localparam int TERM_SV   = 0;
   localparam int TERM_DU   = 1;
   localparam int TERM_WC   = 2;

endpackage

`default_nettype wire

[hdl/qvr_front.sv]
// Front pipeline: products, sums and the cubic numerator of q*v*conj(q).
// Uses qvr_pkg. Six register stages; output is magnitude, sign and norm.
`timescale 1ns / 1ps
`default_nettype none

module qvr_front
   import qvr_pkg::*;
#(
   parameter int W = 32,
   localparam int CW = 3*W+2,
   localparam int NW = 2*W+1
)(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [W-1:0]            quat_x,
   input  logic signed [W-1:0]            quat_y,
   input  logic signed [W-1:0]            quat_z,
   input  logic signed [W-1:0]            quat_w,
   input  logic signed [W-1:0]            vec_x,
   input  logic signed [W-1:0]            vec_y,
   input  logic signed [W-1:0]            vec_z,
   output logic                           out_valid,
   output logic [NUM_AXES-1:0][CW-1:0]    out_mag,
   output logic [NUM_AXES-1:0]            out_neg,
   output logic [NW-1:0]                  out_norm,
   output logic                           out_zero
);

   localparam int PW = 2*W;
   localparam int AW = 2*W+2;
   localparam int NSTAGE = 6;

   logic [NSTAGE-1:0] vld_ff, vld_in;

   // stage 1: raw products
   logic signed [PW-1:0] sq1_ff [NUM_AXES+1], sq1_in [NUM_AXES+1];
   logic signed [PW-1:0] dot1_ff [NUM_AXES], dot1_in [NUM_AXES];
   logic signed [PW-1:0] cp1_ff [NUM_AXES], cp1_in [NUM_AXES];
   logic signed [PW-1:0] cn1_ff [NUM_AXES], cn1_in [NUM_AXES];
   logic signed [W-1:0]  u1_ff [NUM_AXES], u1_in [NUM_AXES];
   logic signed [W-1:0]  v1_ff [NUM_AXES], v1_in [NUM_AXES];
   logic signed [W-1:0]  w1_ff, w1_in;

   // stage 2: norm, scalar factor, dot, cross
   logic [NW-1:0]        n2_ff, n2_in;
   logic signed [AW-1:0] s2_ff, s2_in;
   logic signed [AW-1:0] d2_ff, d2_in;
   logic signed [AW-1:0] cr2_ff [NUM_AXES], cr2_in [NUM_AXES];
   logic signed [W-1:0]  u2_ff [NUM_AXES], u2_in [NUM_AXES];
   logic signed [W-1:0]  v2_ff [NUM_AXES], v2_in [NUM_AXES];
   logic signed [W-1:0]  w2_ff, w2_in;

   // stage 3: split partial products
   logic signed [2*W:0]   lo3_ff [NUM_AXES][NUM_TERMS], lo3_in [NUM_AXES][NUM_TERMS];
   logic signed [2*W+1:0] hi3_ff [NUM_AXES][NUM_TERMS], hi3_in [NUM_AXES][NUM_TERMS];
   logic [NW-1:0]         n3_ff, n3_in;

   // stage 4: recombined terms
   logic signed [CW-1:0] t4_ff [NUM_AXES][NUM_TERMS], t4_in [NUM_AXES][NUM_TERMS];
   logic [NW-1:0]        n4_ff, n4_in;

   // stage 5: numerator
   logic signed [CW-1:0] c5_ff [NUM_AXES], c5_in [NUM_AXES];
   logic [NW-1:0]        n5_ff, n5_in;

   // stage 6: magnitude and flags
   logic [NUM_AXES-1:0][CW-1:0] mag6_ff, mag6_in;
   logic [NUM_AXES-1:0]         neg6_ff, neg6_in;
   logic [NW-1:0]               n6_ff, n6_in;
   logic                        zero6_ff, zero6_in;

   assign vld_in = {vld_ff[NSTAGE-2:0], in_valid};

   always_comb begin
      int i1;
      int i2;
      u1_in[0] = quat_x;
      u1_in[1] = quat_y;
      u1_in[2] = quat_z;
      v1_in[0] = vec_x;
      v1_in[1] = vec_y;
      v1_in[2] = vec_z;
      w1_in    = quat_w;
      for (int i = 0; i < NUM_AXES; i++) begin
         i1 = (i == NUM_AXES-1) ? 0 : i+1;
         i2 = (i1 == NUM_AXES-1) ? 0 : i1+1;
         sq1_in[i]  = u1_in[i] * u1_in[i];
         dot1_in[i] = u1_in[i] * v1_in[i];
         cp1_in[i]  = u1_in[i1] * v1_in[i2];
         cn1_in[i]  = u1_in[i2] * v1_in[i1];
      end
      sq1_in[NUM_AXES] = quat_w * quat_w;
   end

   always_comb begin
      logic signed [AW-1:0] nsum;
      nsum  = AW'(sq1_ff[0]) + AW'(sq1_ff[1]) + AW'(sq1_ff[2]) + AW'(sq1_ff[NUM_AXES]);
      n2_in = nsum[NW-1:0];
      s2_in = AW'(sq1_ff[NUM_AXES]) - AW'(sq1_ff[0]) - AW'(sq1_ff[1]) - AW'(sq1_ff[2]);
      d2_in = AW'(dot1_ff[0]) + AW'(dot1_ff[1]) + AW'(dot1_ff[2]);
      for (int i = 0; i < NUM_AXES; i++) begin
         cr2_in[i] = AW'(cp1_ff[i]) - AW'(cn1_ff[i]);
         u2_in[i]  = u1_ff[i];
         v2_in[i]  = v1_ff[i];
      end
      w2_in = w1_ff;
   end

   // wide operand split into an unsigned low word and a signed high part
   always_comb begin
      logic signed [AW-1:0] a;
      logic signed [W-1:0]  b;
      for (int i = 0; i < NUM_AXES; i++) begin
         for (int k = 0; k < NUM_TERMS; k++) begin
            case (k)
               TERM_SV: begin
                  a = s2_ff;
                  b = v2_ff[i];
               end
               TERM_DU: begin
                  a = d2_ff;
                  b = u2_ff[i];
               end
               default: begin
                  a = cr2_ff[i];
                  b = w2_ff;
               end
            endcase
            lo3_in[i][k] = $signed({1'b0, a[W-1:0]}) * b;
            hi3_in[i][k] = $signed(a[AW-1:W]) * b;
         end
      end
      n3_in = n2_ff;
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         for (int k = 0; k < NUM_TERMS; k++) begin
            t4_in[i][k] = (CW'(hi3_ff[i][k]) <<< W) + CW'(lo3_ff[i][k]);
         end
      end
      n4_in = n3_ff;
   end

   // C = s*v + 2*(d*u + w*cross)
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         c5_in[i] = t4_ff[i][TERM_SV] + ((t4_ff[i][TERM_DU] + t4_ff[i][TERM_WC]) <<< 1);
      end
      n5_in = n4_ff;
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         neg6_in[i] = c5_ff[i][CW-1];
         mag6_in[i] = c5_ff[i][CW-1] ? CW'(-c5_ff[i]) : CW'(c5_ff[i]);
      end
      n6_in    = n5_ff;
      zero6_in = (n5_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq1_ff   <= sq1_in;
         dot1_ff  <= dot1_in;
         cp1_ff   <= cp1_in;
         cn1_ff   <= cn1_in;
         u1_ff    <= u1_in;
         v1_ff    <= v1_in;
         w1_ff    <= w1_in;
         n2_ff    <= n2_in;
         s2_ff    <= s2_in;
         d2_ff    <= d2_in;
         cr2_ff   <= cr2_in;
         u2_ff    <= u2_in;
         v2_ff    <= v2_in;
         w2_ff    <= w2_in;
         lo3_ff   <= lo3_in;
         hi3_ff   <= hi3_in;
         n3_ff    <= n3_in;
         t4_ff    <= t4_in;
         n4_ff    <= n4_in;
         c5_ff    <= c5_in;
         n5_ff    <= n5_in;
         mag6_ff  <= mag6_in;
         neg6_ff  <= neg6_in;
         n6_ff    <= n6_in;
         zero6_ff <= zero6_in;
      end
   end

   assign out_valid = vld_ff[NSTAGE-1];
   assign out_mag   = mag6_ff;
   assign out_neg   = neg6_ff;
   assign out_norm  = n6_ff;
   assign out_zero  = zero6_ff;

endmodule

`default_nettype wire

[hdl/qvr_divide.sv]
// Pipelined restoring divider for three axes, one quotient bit per stage,
// then round-half-away and saturation into the output register. Uses qvr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvr_divide
   import qvr_pkg::*;
#(
   parameter int W = 32,
   localparam int CW = 3*W+2,
   localparam int NW = 2*W+1
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [NUM_AXES-1:0][CW-1:0]   in_mag,
   input  logic [NUM_AXES-1:0]           in_neg,
   input  logic [NW-1:0]                 in_norm,
   input  logic                          in_zero,
   output logic                          out_valid,
   output logic [NUM_AXES-1:0][W-1:0]    out_rot,
   output status_type                    out_status
);

   localparam int NDIV = W+1;   // overflow check plus one stage per bit

   logic [CW-1:0] rem_ff [NDIV][NUM_AXES], rem_in [NDIV][NUM_AXES];
   logic [W-1:0]  quo_ff [NDIV][NUM_AXES], quo_in [NDIV][NUM_AXES];
   logic          huge_ff [NDIV][NUM_AXES], huge_in [NDIV][NUM_AXES];
   logic          neg_ff [NDIV][NUM_AXES], neg_in [NDIV][NUM_AXES];
   logic [NW-1:0] norm_ff [NDIV], norm_in [NDIV];
   logic          zero_ff [NDIV], zero_in [NDIV];
   logic          vld_ff [NDIV], vld_in [NDIV];

   logic [NUM_AXES-1:0][W-1:0] rot_ff, rot_in;
   status_type                 status_ff, status_in;
   logic                       ovld_ff;

   for (genvar g = 0; g < NDIV; g++) begin : g_stage
      if (g == 0) begin : g_check
         // quotient of 2^W or more saturates whatever the sign
         always_comb begin
            for (int i = 0; i < NUM_AXES; i++) begin
               rem_in[g][i]  = in_mag[i];
               quo_in[g][i]  = '0;
               huge_in[g][i] = in_mag[i] >= (CW'(in_norm) << W);
               neg_in[g][i]  = in_neg[i];
            end
            norm_in[g] = in_norm;
            zero_in[g] = in_zero;
            vld_in[g]  = in_valid;
         end
      end else begin : g_bit
         always_comb begin
            logic [CW-1:0] trial;
            trial = CW'(norm_ff[g-1]) << (W-g);
            for (int i = 0; i < NUM_AXES; i++) begin
               if (rem_ff[g-1][i] >= trial) begin
                  rem_in[g][i] = rem_ff[g-1][i] - trial;
                  quo_in[g][i] = quo_ff[g-1][i] | (W'(1) << (W-g));
               end else begin
                  rem_in[g][i] = rem_ff[g-1][i];
                  quo_in[g][i] = quo_ff[g-1][i];
               end
               huge_in[g][i] = huge_ff[g-1][i];
               neg_in[g][i]  = neg_ff[g-1][i];
            end
            norm_in[g] = norm_ff[g-1];
            zero_in[g] = zero_ff[g-1];
            vld_in[g]  = vld_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_in[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in[g];
            quo_ff[g]  <= quo_in[g];
            huge_ff[g] <= huge_in[g];
            neg_ff[g]  <= neg_in[g];
            norm_ff[g] <= norm_in[g];
            zero_ff[g] <= zero_in[g];
         end
      end
   end

   // round half away from zero, then clamp to the signed word
   always_comb begin
      logic [W:0]  pos_max;
      logic [W:0]  neg_mag;
      logic [W:0]  q;
      logic [W:0]  nq;
      logic [NW:0] twice;
      logic        rnd;
      logic        over;
      logic        any_sat;
      pos_max = {2'b00, {(W-1){1'b1}}};
      neg_mag = {2'b01, {(W-1){1'b0}}};
      any_sat = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         twice = {rem_ff[NDIV-1][i][NW-1:0], 1'b0};
         rnd   = twice >= {1'b0, norm_ff[NDIV-1]};
         q     = {1'b0, quo_ff[NDIV-1][i]} + (W+1)'(rnd);
         nq    = -q;
         if (neg_ff[NDIV-1][i]) begin
            over      = huge_ff[NDIV-1][i] || (q > neg_mag);
            rot_in[i] = over ? neg_mag[W-1:0] : nq[W-1:0];
         end else begin
            over      = huge_ff[NDIV-1][i] || (q > pos_max);
            rot_in[i] = over ? pos_max[W-1:0] : q[W-1:0];
         end
         any_sat = any_sat | over;
      end
      if (zero_ff[NDIV-1]) begin
         rot_in    = '0;
         status_in = STATUS_ZERO;
      end else if (any_sat) begin
         status_in = STATUS_SAT;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (en) begin
         ovld_ff <= vld_ff[NDIV-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff    <= rot_in;
         status_ff <= status_in;
      end
   end

   assign out_valid  = ovld_ff;
   assign out_rot    = rot_ff;
   assign out_status = status_ff;

endmodule

`default_nettype wire

[hdl/quaternion_vector_rotate.sv]
// Path from req transfer to rsp_tvalid: six front stages, WORD_BITS+1 divider
//   stages, one output register.
// Throughput: one transfer per cycle while the output is not stalled; set by the
//   fully pipelined multiplier stages and the one-bit-per-stage divider.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_vector_rotate_defines.svh"

module quaternion_vector_rotate
   import qvr_pkg::*;
#(
   parameter int WORD_BITS = 32
)(
   input  logic                                     clock,
   input  logic                                     reset,
   // request: quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z (low to high)
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((7*WORD_BITS+7)/8)*8-1:0]         req_tdata,
   // response: rot_x, rot_y, rot_z (low to high)
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((3*WORD_BITS+7)/8)*8-1:0]         rsp_tdata,
   // response: status
   output logic [STATUS_BITS-1:0]                   rsp_tuser
);

   localparam int W        = WORD_BITS;
   localparam int CW       = 3*W+2;
   localparam int NW       = 2*W+1;
   localparam int OUT_BITS = ((3*WORD_BITS+7)/8)*8;

   logic                        en;
   logic                        f_valid;
   logic [NUM_AXES-1:0][CW-1:0] f_mag;
   logic [NUM_AXES-1:0]         f_neg;
   logic [NW-1:0]               f_norm;
   logic                        f_zero;
   logic [NUM_AXES-1:0][W-1:0]  rot;
   status_type                  status;

   // The whole pipe advances together. It only holds when a finished result
   // sits in the output register and the sink does not take it, so bubbles
   // inside are drained whenever the output side moves.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // Front: q*v*conj(q) as s*v + 2(u.v)u + 2w(u x v), plus the squared norm.
   qvr_front #(
      .W (W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .quat_x    ($signed(req_tdata[W-1:0])),
      .quat_y    ($signed(req_tdata[2*W-1:W])),
      .quat_z    ($signed(req_tdata[3*W-1:2*W])),
      .quat_w    ($signed(req_tdata[4*W-1:3*W])),
      .vec_x     ($signed(req_tdata[5*W-1:4*W])),
      .vec_y     ($signed(req_tdata[6*W-1:5*W])),
      .vec_z     ($signed(req_tdata[7*W-1:6*W])),
      .out_valid (f_valid),
      .out_mag   (f_mag),
      .out_neg   (f_neg),
      .out_norm  (f_norm),
      .out_zero  (f_zero)
   );

   // Back: |C| / norm with rounding, sign restore and clamping. Its last
   // register is the block's output register.
   qvr_divide #(
      .W (W)
   ) u_divide (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (f_valid),
      .in_mag     (f_mag),
      .in_neg     (f_neg),
      .in_norm    (f_norm),
      .in_zero    (f_zero),
      .out_valid  (rsp_tvalid),
      .out_rot    (rot),
      .out_status (status)
   );

   assign rsp_tdata = OUT_BITS'({rot[2], rot[1], rot[0]});
   assign rsp_tuser = status;

   // zero-norm results carry all-zero vectors
   `QVR_ASSERT_IMPLIES(a_zero_clears, clock, reset, rsp_tvalid && (rsp_tuser == STATUS_ZERO), rot == '0)
   // only the three defined status codes leave the block
   `QVR_ASSERT_IMPLIES(a_status_legal, clock, reset, rsp_tvalid, (rsp_tuser == STATUS_OK) || (rsp_tuser == STATUS_ZERO) || (rsp_tuser == STATUS_SAT))
   // input is held back only by a stalled, full output register
   `QVR_ASSERT_IMPLIES(a_stall_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)
   // a stalled result is not dropped
   `QVR_ASSERT_NEXT(a_stall_keeps, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

endmodule

`default_nettype wire

[dv/quaternion_vector_rotate_tb.sv]
// Testbench for quaternion_vector_rotate: random and directed quaternion/vector transfers,
// checked against an exact integer predictor held in a scoreboard class.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
`timescale 1ns / 1ps

module quaternion_vector_rotate_tb;
   import qvr_pkg::*;

   localparam int W         = 32;
   localparam int REQ_BITS  = ((7*W+7)/8)*8;
   localparam int RSP_BITS  = ((3*W+7)/8)*8;
   localparam int LATENCY   = W + 8;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [W-1:0] vz, vy, vx, qw, qz, qy, qx;
   } rot_req_t;

   typedef struct {
      logic signed [W-1:0] rx, ry, rz;
      status_type          st;
   } rot_rsp_t;

   // Rotation predictor plus queue of pending results.
   class rotation_scoreboard;
      rot_rsp_t pending[$];
      int       errors;
      int       checked;
      int       n_zero, n_sat;

      // exact result: round(C / S) with ties away from zero, then clamp
      function rot_rsp_t rotate(rot_req_t r);
         logic signed [255:0] qx, qy, qz, qw, vx, vy, vz, nrm;
         logic signed [255:0] px, py, pz, pw, c[3], mag, quo, rem;
         logic signed [255:0] maxp, maxn;
         rot_rsp_t o;
         logic sat;
         qx = r.qx; qy = r.qy; qz = r.qz; qw = r.qw;
         vx = r.vx; vy = r.vy; vz = r.vz;
         nrm = qx*qx + qy*qy + qz*qz + qw*qw;
         if (nrm == 0) begin
            o.rx = '0; o.ry = '0; o.rz = '0; o.st = STATUS_ZERO;
            return o;
         end
         // p = v * conj(q), v pure
         pw = vx*qx + vy*qy + vz*qz;
         px = vx*qw - vy*qz + vz*qy;
         py = vy*qw - vz*qx + vx*qz;
         pz = vz*qw - vx*qy + vy*qx;
         // c = q * p, vector part
         c[0] = qx*pw + px*qw + qy*pz - qz*py;
         c[1] = qy*pw + py*qw + qz*px - qx*pz;
         c[2] = qz*pw + pz*qw + qx*py - qy*px;
         maxp = (256'sd1 <<< (W-1)) - 1;
         maxn = -(256'sd1 <<< (W-1));
         sat = 0;
         for (int i = 0; i < 3; i++) begin
            mag = c[i] < 0 ? -c[i] : c[i];
            quo = mag / nrm;
            rem = mag % nrm;
            if (2*rem >= nrm) quo = quo + 1;
            if (c[i] < 0) quo = -quo;
            if (quo > maxp) begin quo = maxp; sat = 1; end
            if (quo < maxn) begin quo = maxn; sat = 1; end
            c[i] = quo;
         end
         o.rx = c[0][W-1:0]; o.ry = c[1][W-1:0]; o.rz = c[2][W-1:0];
         o.st = sat ? STATUS_SAT : STATUS_OK;
         return o;
      endfunction

      function void note_request(rot_req_t r);
         rot_rsp_t e;
         e = rotate(r);
         if (e.st == STATUS_ZERO) n_zero++;
         if (e.st == STATUS_SAT) n_sat++;
         pending.push_back(e);
      endfunction

      function void check_result(logic [RSP_BITS-1:0] d, status_type st);
         rot_rsp_t e;
         if (pending.size() == 0) begin
            $error("unexpected result transfer: rot 0x%0h status %0d", d, st);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (d[W-1:0] !== e.rx) begin
            $error("rot_x exp %0d got %0d", e.rx, $signed(d[W-1:0])); errors++;
         end
         if (d[2*W-1:W] !== e.ry) begin
            $error("rot_y exp %0d got %0d", e.ry, $signed(d[2*W-1:W])); errors++;
         end
         if (d[3*W-1:2*W] !== e.rz) begin
            $error("rot_z exp %0d got %0d", e.rz, $signed(d[3*W-1:2*W])); errors++;
         end
         if (st !== e.st) begin
            $error("status exp %0d got %0d", e.st, st); errors++;
         end
      endfunction
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0] rsp_tuser;

   rotation_scoreboard sb = new();

   // idle percentages per phase, set by the stimulus process
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 0;     // long receiver stall request
   longint cycles = 0;

   quaternion_vector_rotate #(.WORD_BITS(W)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: sample on rising edge, change tready on falling edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold_off && hold == 0) hold = 300;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 0;
            if (hold == 0) hold_off = 0;
         end else
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // one request transfer; random idle cycles before it
   // valid stays high after the transfer until the next call or drain()
   task automatic send_rotation(rot_req_t r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1;
      req_tdata  <= REQ_BITS'(r);
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   function automatic logic [W-1:0] rand_word();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         1: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);  // near unit
         2: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
         3: return 32'($urandom_range(3)) - 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic rot_req_t rand_rotation();
      rot_req_t r;
      r.qx = rand_word(); r.qy = rand_word(); r.qz = rand_word(); r.qw = rand_word();
      r.vx = rand_word(); r.vy = rand_word(); r.vz = rand_word();
      if ($urandom_range(19) == 0) begin r.qx = 0; r.qy = 0; r.qz = 0; r.qw = 0; end
      return r;
   endfunction

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      rot_req_t r;
      int pct[4][2];
      pct = '{'{0, 0}, '{45, 0}, '{0, 45}, '{33, 33}};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: identity, zero norm, extremes and exact axis rotations
      r = '{vz: 3 << 16, vy: 2 << 16, vx: 1 << 16, qw: 1 << 16, qz: 0, qy: 0, qx: 0};
      send_rotation(r);
      r = '{vz: 5, vy: -7, vx: 9, qw: 0, qz: 0, qy: 0, qx: 0};  // zero norm
      send_rotation(r);
      r = '{default: 32'h80000000};
      send_rotation(r);
      r = '{default: 32'h7fffffff};
      send_rotation(r);
      r = '{vz: 0, vy: 0, vx: 32'h7fffffff, qw: 1, qz: 1, qy: 0, qx: 0};  // 90 deg
      send_rotation(r);
      r = '{vz: 32'h80000000, vy: 32'h7fffffff, vx: 32'h80000000,
            qw: 1, qz: 1, qy: 1, qx: 1};
      send_rotation(r);
      r = '{vz: 1, vy: 1, vx: 1, qw: 1, qz: 0, qy: 1, qx: 0};        // 90 deg about y
      send_rotation(r);
      r = '{vz: -1, vy: 3, vx: -3, qw: 2, qz: 0, qy: 0, qx: 1};
      send_rotation(r);
      r = '{vz: 32'hffffffff, vy: 0, vx: 0, qw: 0, qz: 0, qy: 0, qx: 32'h80000000};
      send_rotation(r);
      for (int i = 0; i < 8; i++) begin
         r = rand_rotation();
         r.qx = 0; r.qy = 0; r.qz = 0; r.qw = 0;
         if (i < 4) r.qx = (i & 1) ? 32'h80000000 : 1;
         send_rotation(r);
      end
      // sender pause until all results are back
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = pct[ph][0];
         recv_stall_pct = pct[ph][1];
         if (ph == 1) hold_off = 1;   // block backs up while we keep offering
         for (int i = 0; i < 185; i++) begin
            // occasional bursts with no idling at all
            if (i % 60 < 15) begin
               send_idle_pct = 0; recv_stall_pct = 0;
            end else begin
               send_idle_pct = pct[ph][0]; recv_stall_pct = pct[ph][1];
            end
            send_rotation(rand_rotation());
         end
      end
      recv_stall_pct = 0;
      drain();
      repeat (LATENCY + 10) @(negedge clock);

      $display("Run covered %0d rotations (%0d zero-norm, %0d saturated) over four idle phases.",
               sb.checked, sb.n_zero, sb.n_sat);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/qvr_pkg.sv
hdl/qvr_front.sv
hdl/qvr_divide.sv
hdl/quaternion_vector_rotate.sv
dv/quaternion_vector_rotate_tb.sv
